FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the ray marcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: design/dfrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfrm_pkg
// Types, constants and the distance function of the distance field ray marcher.
// ----------------------------------------------------------------------------
package dfrm_pkg;

  localparam int DIR_W      = 16;
  localparam int ROT_W      = 19;
  localparam int DIST_W     = 19;
  localparam int POS_W      = 32;
  localparam int TRIG_W     = 14;
  localparam int MODE_W     = 2;
  localparam int STEPS_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W     = 12;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COS   = 3'd5;

  // Scene modes.
  localparam logic [MODE_W-1:0] MODE_BOX  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWAP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GRID = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FOLD = 2'd3;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 14'sd4096;

  localparam logic signed [DIST_W-1:0] HIT_LIMIT = 19'sh200;
  localparam logic signed [DIST_W-1:0] OFS_BOX   = 19'sh8000;
  localparam logic signed [DIST_W-1:0] OFS_SWAP  = 19'sh5000;
  localparam logic signed [DIST_W-1:0] OFS_FOLD  = 19'sh3000;
  localparam logic [POS_W-1:0]         MASK_Y    = 32'hc3c3c000;
  localparam logic [POS_W-1:0]         MASK_Z    = 32'hF0F0F0F0;

  // Operand selections of the shared multiplier.
  localparam logic [2:0] MUL_U_COS = 3'd0;
  localparam logic [2:0] MUL_Z_SIN = 3'd1;
  localparam logic [2:0] MUL_Z_COS = 3'd2;
  localparam logic [2:0] MUL_U_SIN = 3'd3;
  localparam logic [2:0] MUL_X_D   = 3'd4;
  localparam logic [2:0] MUL_Y_D   = 3'd5;
  localparam logic [2:0] MUL_Z_D   = 3'd6;
  localparam logic [2:0] MUL_NONE  = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         org_x;
    logic [POS_W-1:0]         org_y;
    logic [POS_W-1:0]         org_z;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic [2:0] mul_op;
    logic       acc_load;
    logic       rot_a;
    logic       rot_b;
    logic       add_x;
    logic       add_y;
    logic       add_z;
    logic       take_d;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic left_zero;
    logic hit;
    logic out_free;
  } status_t;

  // Ones' complement of negative words, so both halves of space fold together.
  function automatic logic [POS_W-1:0] fold32(input logic [POS_W-1:0] v);
    return v[POS_W-1] ? ~v : v;
  endfunction

  function automatic logic signed [DIST_W-1:0] distance(
    input logic [MODE_W-1:0] mode,
    input logic [POS_W-1:0]  px,
    input logic [POS_W-1:0]  py,
    input logic [POS_W-1:0]  pz
  );
    logic [POS_W-1:0]         fx, fy, fz, yterm, zterm;
    logic signed [DIST_W-1:0] sx, sy, sz, ty, tz, sum_yz, diff, dfold, res;
    fx     = fold32(px);
    fy     = fold32(py);
    fz     = fold32(pz);
    sx     = DIST_W'(fx[31:16]);
    sy     = DIST_W'(fy[31:16]);
    sz     = DIST_W'(fz[31:16]);
    yterm  = {15'b0, fy[31:15]} & MASK_Y;
    zterm  = {16'b0, fz[31:16]} & MASK_Z;
    ty     = DIST_W'(yterm);
    tz     = DIST_W'(zterm);
    sum_yz = sy + sz;
    diff   = sx - sz;
    dfold  = diff[DIST_W-1] ? ~diff : diff;
    case (mode)
      MODE_BOX:  res = sx + sy + tz - OFS_BOX;
      MODE_SWAP: res = (sx | sum_yz) - OFS_SWAP;
      MODE_GRID: res = sx + ty + tz - OFS_BOX;
      default:   res = dfold + sy - OFS_FOLD;
    endcase
    return res;
  endfunction

endpackage

FILE: design/dfrm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfrm_cfg_regs
// Configuration register file: scene mode, ray origin and view rotation.
// ----------------------------------------------------------------------------
module dfrm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dfrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfrm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dfrm_pkg::cfg_t                   cfg
);
  import dfrm_pkg::*;

  // Writes are refused while reset holds the registers at their defaults.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_BOX;
      cfg.org_x <= '0;
      cfg.org_y <= '0;
      cfg.org_z <= '0;
      cfg.sin_v <= '0;
      cfg.cos_v <= COS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:  cfg.mode  <= cfg_data[MODE_W-1:0];
        REG_ORG_X: cfg.org_x <= cfg_data;
        REG_ORG_Y: cfg.org_y <= cfg_data;
        REG_ORG_Z: cfg.org_z <= cfg_data;
        REG_SIN:   cfg.sin_v <= $signed(cfg_data[TRIG_W-1:0]);
        REG_COS:   cfg.cos_v <= $signed(cfg_data[TRIG_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/dfrm_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// dfrm_ctrl
// Sequencer for rotation and the march loop around the shared multiplier.
// ----------------------------------------------------------------------------
module dfrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfrm_pkg::status_t status,
  output dfrm_pkg::cmd_t    cmd
);
  import dfrm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_R0   = 4'd1;
  localparam logic [3:0] S_R1   = 4'd2;
  localparam logic [3:0] S_R2   = 4'd3;
  localparam logic [3:0] S_R3   = 4'd4;
  localparam logic [3:0] S_R4   = 4'd5;
  localparam logic [3:0] S_DIST = 4'd6;
  localparam logic [3:0] S_MX   = 4'd7;
  localparam logic [3:0] S_MY   = 4'd8;
  localparam logic [3:0] S_MZ   = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        // No beat is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_R0;
        end
      end
      S_R0: begin
        cmd.mul_op = MUL_U_COS;
        state_next = S_R1;
      end
      S_R1: begin
        cmd.mul_op   = MUL_Z_SIN;
        cmd.acc_load = 1'b1;
        state_next   = S_R2;
      end
      S_R2: begin
        cmd.mul_op = MUL_Z_COS;
        cmd.rot_a  = 1'b1;
        state_next = S_R3;
      end
      S_R3: begin
        cmd.mul_op   = MUL_U_SIN;
        cmd.acc_load = 1'b1;
        state_next   = S_R4;
      end
      S_R4: begin
        cmd.rot_b  = 1'b1;
        state_next = S_DIST;
      end
      S_DIST: begin
        // The march ends on a hit or when the step budget is spent; the
        // result waits here until the output register can take it.
        if (status.left_zero || status.hit) begin
          if (status.out_free) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.take_d = 1'b1;
          state_next = S_MX;
        end
      end
      S_MX: begin
        cmd.mul_op = MUL_X_D;
        state_next = S_MY;
      end
      S_MY: begin
        cmd.mul_op = MUL_Y_D;
        cmd.add_x  = 1'b1;
        state_next = S_MZ;
      end
      S_MZ: begin
        cmd.mul_op = MUL_Z_D;
        cmd.add_y  = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.add_z  = 1'b1;
        state_next = S_DIST;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_finish_needs_end, cmd.finish |-> (status.hit || status.left_zero))
  `ASSERT_CLK(a_finish_needs_room, cmd.finish |-> status.out_free)
  `ASSERT_CLK(a_step_only_on_miss, cmd.take_d |-> (!status.hit && !status.left_zero))

endmodule

FILE: design/dfrm_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// dfrm_datapath
// Ray direction and position registers, shared multiplier, distance field
// evaluation and the result register.
// ----------------------------------------------------------------------------
module dfrm_datapath #(
  parameter int MAX_STEPS = 31
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dfrm_pkg::cfg_t                      cfg,
  input  dfrm_pkg::cmd_t                      cmd,
  output dfrm_pkg::status_t                   status,
  input  logic signed [dfrm_pkg::DIR_W-1:0]   dir_first,
  input  logic signed [dfrm_pkg::DIR_W-1:0]   dir_second,
  input  logic signed [dfrm_pkg::DIR_W-1:0]   dir_third,
  output logic [dfrm_pkg::STEPS_W-1:0]        steps_left,
  output logic                                out_valid,
  input  logic                                out_ready
);
  import dfrm_pkg::*;

  localparam int LEFT_W = $clog2(MAX_STEPS + 1);
  localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(MAX_STEPS);
  localparam int PROD_W = 2 * ROT_W;

  logic signed [ROT_W-1:0]  dx, dy, dz, rot_a;
  logic [POS_W-1:0]         px, py, pz;
  logic [POS_W-1:0]         prod;
  logic signed [POS_W-1:0]  acc;
  logic signed [DIST_W-1:0] d_reg;
  logic [LEFT_W-1:0]        left;

  logic signed [ROT_W-1:0]  u_dir, sin_e, cos_e, op_a, op_b;
  logic signed [PROD_W-1:0] mul_full;
  logic signed [POS_W-1:0]  sum_a, diff_b;
  logic signed [DIST_W-1:0] d_now;
  logic [LEFT_W+STEPS_W-1:0] left_ext;

  // The rotated pair is x/z in modes 0 and 2, y/z in modes 1 and 3.
  assign u_dir    = cfg.mode[0] ? dy : dx;
  assign sin_e    = ROT_W'(cfg.sin_v);
  assign cos_e    = ROT_W'(cfg.cos_v);
  assign d_now    = distance(cfg.mode, px, py, pz);
  assign sum_a    = acc + $signed(prod);
  assign diff_b   = acc - $signed(prod);
  assign left_ext = (LEFT_W + STEPS_W)'(left);

  always_comb begin
    case (cmd.mul_op)
      MUL_U_COS: begin op_a = u_dir; op_b = cos_e; end
      MUL_Z_SIN: begin op_a = dz;    op_b = sin_e; end
      MUL_Z_COS: begin op_a = dz;    op_b = cos_e; end
      MUL_U_SIN: begin op_a = u_dir; op_b = sin_e; end
      MUL_X_D:   begin op_a = dx;    op_b = d_reg; end
      MUL_Y_D:   begin op_a = dy;    op_b = d_reg; end
      MUL_Z_D:   begin op_a = dz;    op_b = d_reg; end
      default:   begin op_a = '0;    op_b = '0;    end
    endcase
  end

  assign mul_full = op_a * op_b;

  assign status.left_zero = (left == '0);
  assign status.hit       = (d_now < HIT_LIMIT);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    // Only the low word of a product is ever used: rotation sums stay far
    // below 2^31 and position updates wrap at 32 bits.
    prod <= mul_full[POS_W-1:0];
    if (cmd.load) begin
      px <= cfg.org_x;
      py <= cfg.org_y;
      pz <= cfg.org_z;
      if (cfg.mode == MODE_SWAP) begin
        dy <= ROT_W'(dir_first);
        dz <= ROT_W'(dir_second);
        dx <= ROT_W'(dir_third);
      end else begin
        dx <= ROT_W'(dir_first);
        dy <= ROT_W'(dir_second);
        dz <= ROT_W'(dir_third);
      end
    end
    if (cmd.acc_load) begin
      acc <= $signed(prod);
    end
    if (cmd.rot_a) begin
      rot_a <= sum_a[FRAC_W+ROT_W-1:FRAC_W];
    end
    if (cmd.rot_b) begin
      dz <= diff_b[FRAC_W+ROT_W-1:FRAC_W];
      if (cfg.mode[0]) begin
        dy <= rot_a;
      end else begin
        dx <= rot_a;
      end
    end
    if (cmd.take_d) begin
      d_reg <= d_now;
    end
    if (cmd.add_x) begin
      px <= px + prod;
    end
    if (cmd.add_y) begin
      py <= py + prod;
    end
    if (cmd.add_z) begin
      pz <= pz + prod;
    end
    if (cmd.finish) begin
      steps_left <= left_ext[STEPS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left      <= LEFT_INIT;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        left <= LEFT_INIT;
      end else if (cmd.add_z) begin
        left <= left - 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_left_in_range, left <= LEFT_INIT)
  `ASSERT_CLK(a_step_distance_far, cmd.take_d |=> (d_reg >= HIT_LIMIT))
  `ASSERT_CLK(a_load_restarts_count, cmd.load |=> (left == LEFT_INIT))

endmodule

FILE: design/distance_field_ray_march_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_field_ray_march_top
// Per-pixel distance field ray marcher with a streaming input and output.
// ----------------------------------------------------------------------------
// Each input beat carries one pixel's three ray direction words. The ray is
// rotated by the configured sine and cosine, then marched from the configured
// origin until the mode's distance field drops below 0x200 or MAX_STEPS steps
// are spent; the output beat carries the number of steps left (0 means the
// budget ran out). Everything runs through one shared 19 x 19 multiplier:
// the rotation runs through states R0 to R4, and each march step evaluates
// the distance, then the x, y and z products with their position updates.
// A finished result sits in the output register, so the next pixel is
// accepted while that result waits to be taken. Write the configuration
// registers only while the block is idle.
module distance_field_ray_march_top #(
  parameter int MAX_STEPS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] dir_first, [31:16] dir_second, [47:32] dir_third
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] steps_left, [7:5] zero
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [dfrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfrm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dfrm_pkg::*;

  cfg_t                cfg;
  cmd_t                cmd;
  status_t             status;
  logic [STEPS_W-1:0]  steps_left;

  dfrm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dfrm_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .dir_first  ($signed(s_axis_tdata[15:0])),
    .dir_second ($signed(s_axis_tdata[31:16])),
    .dir_third  ($signed(s_axis_tdata[47:32])),
    .steps_left (steps_left),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {3'b000, steps_left};

endmodule

FILE: tb/tb_distance_field_ray_march_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_field_ray_march_top
// Self-checking bench for the distance field ray marcher: direction beats go
// in, the steps-left count of every pixel is predicted from the configured
// mode, origin and rotation, and each output beat is compared in order.
// ----------------------------------------------------------------------------
import dfrm_pkg::*;

class steps_scoreboard;
  localparam int STEP_LIMIT = 31;
  localparam int NEAR       = 32'sh200;

  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         org_x, org_y, org_z;
  logic signed [TRIG_W-1:0] sin_v, cos_v;
  logic [STEPS_W-1:0]       steps_due[$];
  int                       errors;

  function new();
    mode   = MODE_BOX;
    org_x  = '0;
    org_y  = '0;
    org_z  = '0;
    sin_v  = '0;
    cos_v  = COS_RESET;
    errors = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:  mode  = data[MODE_W-1:0];
      REG_ORG_X: org_x = data;
      REG_ORG_Y: org_y = data;
      REG_ORG_Z: org_z = data;
      REG_SIN:   sin_v = data[TRIG_W-1:0];
      REG_COS:   cos_v = data[TRIG_W-1:0];
      default: ;
    endcase
  endfunction

  function int field_distance(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                              logic [POS_W-1:0] pz);
    logic [POS_W-1:0] fx, fy, fz;
    int               hx, hy, hz, diff;
    // Negative words fold onto positive space by ones' complement.
    fx = px[POS_W-1] ? ~px : px;
    fy = py[POS_W-1] ? ~py : py;
    fz = pz[POS_W-1] ? ~pz : pz;
    hx = int'(fx >> 16);
    hy = int'(fy >> 16);
    hz = int'(fz >> 16);
    case (mode)
      MODE_BOX:  return hx + hy + (hz & 32'sh0000f0f0) - 32'sh8000;
      MODE_SWAP: return (hx | (hy + hz)) - 32'sh5000;
      MODE_GRID: return hx + int'((fy >> 15) & 32'hc3c3c000)
                        + (hz & 32'shF0F0F0F0) - 32'sh8000;
      default: begin
        diff = hx - hz;
        return (diff < 0 ? -diff - 1 : diff) + hy - 32'sh3000;
      end
    endcase
  endfunction

  function logic [STEPS_W-1:0] march_steps_left(logic [47:0] beat);
    logic signed [DIR_W-1:0] w0, w1, w2;
    longint                  dx, dy, dz, c, s, ru, rv;
    int                      ix, iy, iz, d_field;
    logic [POS_W-1:0]        px, py, pz;
    int unsigned             left;
    w0 = beat[15:0];
    w1 = beat[31:16];
    w2 = beat[47:32];
    c  = cos_v;
    s  = sin_v;
    if (mode == MODE_SWAP) begin
      dy = w0;
      dz = w1;
      dx = w2;
    end else begin
      dx = w0;
      dy = w1;
      dz = w2;
    end
    // Exact products, then a flooring shift by the 12 fraction bits.
    if (mode == MODE_BOX || mode == MODE_GRID) begin
      ru = (dx * c + dz * s) >>> FRAC_W;
      rv = (dz * c - dx * s) >>> FRAC_W;
      dx = ru;
      dz = rv;
    end else begin
      ru = (dy * c + dz * s) >>> FRAC_W;
      rv = (dz * c - dy * s) >>> FRAC_W;
      dy = ru;
      dz = rv;
    end
    ix   = int'(dx);
    iy   = int'(dy);
    iz   = int'(dz);
    px   = org_x;
    py   = org_y;
    pz   = org_z;
    left = STEP_LIMIT;
    while (left != 0) begin
      d_field = field_distance(px, py, pz);
      if (d_field < NEAR) break;
      px = px + ix * d_field;
      py = py + iy * d_field;
      pz = pz + iz * d_field;
      left--;
    end
    return STEPS_W'(left);
  endfunction

  function void note_pixel(logic [47:0] beat);
    steps_due.push_back(march_steps_left(beat));
  endfunction

  function void check_result(logic [7:0] beat);
    logic [STEPS_W-1:0] want;
    if (steps_due.size() == 0) begin
      $error("steps_left beat with no pixel pending: expected none, actual %0d",
             beat[STEPS_W-1:0]);
      errors++;
    end else begin
      want = steps_due.pop_front();
      if (beat[STEPS_W-1:0] !== want) begin
        $error("steps_left mismatch: expected %0d, actual %0d", want, beat[STEPS_W-1:0]);
        errors++;
      end
    end
  endfunction
endclass

module tb_distance_field_ray_march_top;
  localparam int STEP_LIMIT  = 31;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 50;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  steps_scoreboard sb;
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              quiet_cycles;

  distance_field_ray_march_top #(
    .MAX_STEPS(STEP_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("distance_field_ray_march_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves tvalid high after the beat so back-to-back pixels need no re-raise.
  task automatic send_pixel(input logic [47:0] beat);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.steps_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] ox,
                           input logic [POS_W-1:0] oy, input logic [POS_W-1:0] oz,
                           input logic [TRIG_W-1:0] sin_bits, input logic [TRIG_W-1:0] cos_bits);
    logic [CFG_DATA_W-1:0] word;
    // Unused upper data bits carry noise; the block must ignore them.
    word = $urandom();
    word[MODE_W-1:0] = mode;
    write_reg(REG_MODE, word);
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_ORG_Z, oz);
    word = $urandom();
    word[TRIG_W-1:0] = sin_bits;
    write_reg(REG_SIN, word);
    word = $urandom();
    word[TRIG_W-1:0] = cos_bits;
    write_reg(REG_COS, word);
    write_reg(REG_COS + 3'd1 + 3'($urandom_range(1)), $urandom());
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] random_origin();
    case ($urandom_range(3))
      0: return '0;
      1: return $urandom();
      2: begin
        case ($urandom_range(2))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          default: return 32'hffffffff;
        endcase
      end
      default: return $urandom_range(32'h000fffff) ^ {32{1'($urandom_range(1))}};
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] random_trig();
    if ($urandom_range(99) < 85) return TRIG_W'($urandom_range(8192) - 4096);
    return TRIG_W'($urandom_range(16383));
  endfunction

  function automatic logic [DIR_W-1:0] random_dir();
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      2, 3, 4: return DIR_W'($urandom_range(1023) ^ {16{1'($urandom_range(1))}});
      default: return DIR_W'($urandom_range(16'hffff));
    endcase
  endfunction

  logic [47:0] edge_dirs [6];

  initial begin
    sb = new();
    edge_dirs[0] = {16'h0000, 16'h0000, 16'h0000};
    edge_dirs[1] = {16'h8000, 16'h8000, 16'h8000};
    edge_dirs[2] = {16'h7fff, 16'h7fff, 16'h7fff};
    edge_dirs[3] = {16'h0000, 16'h8000, 16'h7fff};
    edge_dirs[4] = {16'h8000, 16'h0001, 16'hffff};
    edge_dirs[5] = {16'hf000, 16'h0000, 16'h1000};
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    quiet_cycles  <= 0;
    tx_idle_pct   = 34;
    rx_idle_pct   = 79;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Register values straight out of reset.
    send_pixel({16'h012c, 16'hf830, 16'h03e8});
    send_pixel({16'h7fff, 16'h0400, 16'h8000});
    drain_results();

    // Every mode once, with extreme origins and angles, including angle
    // patterns outside the unit range and origins that wrap on the first step.
    configure(MODE_BOX, 32'h0, 32'h0, 32'h0, 14'd0, 14'd4096);
    for (int k = 0; k < 6; k++) send_pixel(edge_dirs[k]);
    drain_results();
    configure(MODE_SWAP, 32'h7fffffff, 32'h80000000, 32'h12345678, 14'd4096, 14'd0);
    for (int k = 0; k < 6; k++) send_pixel(edge_dirs[k]);
    drain_results();
    configure(MODE_GRID, 32'h80000000, 32'h80000000, 32'h80000000,
              -14'sd4096, -14'sd4096);
    for (int k = 0; k < 6; k++) send_pixel(edge_dirs[k]);
    drain_results();
    configure(MODE_FOLD, 32'h01000000, 32'hff000000, 32'h7fffffff, 14'h1fff, 14'h2000);
    for (int k = 0; k < 6; k++) send_pixel(edge_dirs[k]);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 5) begin
        tx_idle_pct = 34;
        rx_idle_pct = 79;
      end else if (p < 10) begin
        tx_idle_pct = 79;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      configure(MODE_W'($urandom_range(3)), random_origin(), random_origin(),
                random_origin(), random_trig(), random_trig());
      repeat (PHASE_ITEMS) send_pixel({random_dir(), random_dir(), random_dir()});
      drain_results();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.steps_due.size() == 0) begin
      $display("distance_field_ray_march_top test passed");
    end else begin
      $display("distance_field_ray_march_top test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/dfrm_pkg.sv
design/dfrm_cfg_regs.sv
design/dfrm_ctrl.sv
design/dfrm_datapath.sv
design/distance_field_ray_march_top.sv
tb/tb_distance_field_ray_march_top.sv
